// ===== rtl/blvr_pkg.sv =====
// Shared constants for the bidi level visual reorder unit.
package blvr_pkg;

   localparam int LEVEL_W = 7;
   localparam int INDEX_W = 6;

   // Highest usable embedding level; the all-ones code is saturated to it.
   localparam logic [LEVEL_W-1:0] LEVEL_TOP = 7'd126;

endpackage

// ===== rtl/blvr_entry_ram.sv =====
// Line buffer entry memory: one write port and two registered read ports.
module blvr_entry_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 13
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [DATA_W-1:0]        rd_data_a,
   output logic [DATA_W-1:0]        rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds between reads, which the swap sequence relies on.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/bidi_level_visual_reorder_unit.sv =====
// Top level of the bidi level visual reorder unit: loading, pass sequencer and output beat.
// Loading accepts one level beat per cycle; req_stall is low throughout a line until its last beat.
// Reordering runs one pass per level from the highest down to the lowest odd level. A pass reads each
// position in turn (a position closing a run is read twice), then reverses each run by swapping pairs:
// both entries are read, then written back in turn. Each result is read when the output is free.
// Reset is synchronous: line count, level bounds, overflow flag and state are cleared; memory is not.
module bidi_level_visual_reorder_unit #(
   parameter int MAX_LEN = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [blvr_pkg::LEVEL_W-1:0]  req_level,
   input  logic                          req_end_of_line,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [blvr_pkg::INDEX_W-1:0]  rsp_logical_index,
   output logic                          rsp_last_result,
   output logic                          rsp_overflow
);

   import blvr_pkg::*;

   localparam int AW      = $clog2(MAX_LEN);
   localparam int CW      = $clog2(MAX_LEN + 1);
   localparam int ENTRY_W = LEVEL_W + AW;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_PASS      = 4'd1;
   localparam logic [3:0] S_RD_A      = 4'd2;
   localparam logic [3:0] S_CHK_A     = 4'd3;
   localparam logic [3:0] S_RD_B      = 4'd4;
   localparam logic [3:0] S_CHK_B     = 4'd5;
   localparam logic [3:0] S_SWAP_RD   = 4'd6;
   localparam logic [3:0] S_SWAP_W1   = 4'd7;
   localparam logic [3:0] S_SWAP_W2   = 4'd8;
   localparam logic [3:0] S_EMIT_RD   = 4'd9;
   localparam logic [3:0] S_EMIT_LOAD = 4'd10;

   logic [3:0]         state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [LEVEL_W-1:0] high_ff, high_in;
   logic [LEVEL_W-1:0] low_ff, low_in;
   logic               ovf_ff, ovf_in;
   logic [LEVEL_W-1:0] lv_ff, lv_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr_a;
   logic [AW-1:0]      rd_addr_b;
   logic [ENTRY_W-1:0] rd_data_a;
   logic [ENTRY_W-1:0] rd_data_b;

   logic               req_accept;
   logic [LEVEL_W-1:0] level_sat;
   logic               room;
   logic [LEVEL_W-1:0] bottom;
   logic               pass_on;
   logic [LEVEL_W-1:0] rd_level;
   logic               out_free;
   logic               emit_last;
   logic [CW-1:0]      hi_last;

   // Each entry carries its level alongside its logical index, so both travel together on a swap.
   blvr_entry_ram #(
      .DEPTH  (MAX_LEN),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && (state_ff == S_IDLE);
   assign level_sat  = (req_level > LEVEL_TOP) ? LEVEL_TOP : req_level;
   assign room       = (count_ff < CW'(MAX_LEN));
   assign bottom     = low_ff[0] ? low_ff : low_ff + LEVEL_W'(1);
   assign pass_on    = (lv_ff >= bottom) && (lv_ff != '0);
   assign rd_level   = rd_data_a[ENTRY_W-1:AW];
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_last  = ((pos_ff + CW'(1)) == count_ff);
   assign hi_last    = hi_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      ovf_in       = ovf_ff;
      lv_in        = lv_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (room) begin
                  // Loading in place also sets up the identity order.
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = {level_sat, count_ff[AW-1:0]};
                  count_in = count_ff + CW'(1);
                  if (level_sat > high_ff) begin
                     high_in = level_sat;
                  end
                  if (level_sat < low_ff) begin
                     low_in = level_sat;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_end_of_line) begin
                  lv_in    = high_in;
                  state_in = S_PASS;
               end
            end
         end
         S_PASS: begin
            pos_in = '0;
            if (pass_on) begin
               state_in = S_RD_A;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_RD_A: begin
            if (pos_ff == count_ff) begin
               lv_in    = lv_ff - LEVEL_W'(1);
               state_in = S_PASS;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = pos_ff[AW-1:0];
               state_in  = S_CHK_A;
            end
         end
         S_CHK_A: begin
            pos_in = pos_ff + CW'(1);
            if (rd_level >= lv_ff) begin
               lo_in    = pos_ff;
               state_in = S_RD_B;
            end else begin
               state_in = S_RD_A;
            end
         end
         S_RD_B: begin
            if (pos_ff == count_ff) begin
               hi_in    = pos_ff;
               state_in = S_SWAP_RD;
            end else begin
               rd_en     = 1'b1;
               rd_addr_a = pos_ff[AW-1:0];
               state_in  = S_CHK_B;
            end
         end
         S_CHK_B: begin
            if (rd_level >= lv_ff) begin
               pos_in   = pos_ff + CW'(1);
               state_in = S_RD_B;
            end else begin
               hi_in    = pos_ff;
               state_in = S_SWAP_RD;
            end
         end
         S_SWAP_RD: begin
            // The run ends just before pos, so scanning resumes there once it is reversed.
            if ((lo_ff + CW'(1)) < hi_ff) begin
               rd_en     = 1'b1;
               rd_addr_a = lo_ff[AW-1:0];
               rd_addr_b = hi_last[AW-1:0];
               state_in  = S_SWAP_W1;
            end else begin
               state_in = S_RD_A;
            end
         end
         S_SWAP_W1: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = rd_data_b;
            state_in = S_SWAP_W2;
         end
         S_SWAP_W2: begin
            wr_en    = 1'b1;
            wr_addr  = hi_last[AW-1:0];
            wr_data  = rd_data_a;
            lo_in    = lo_ff + CW'(1);
            hi_in    = hi_ff - CW'(1);
            state_in = S_SWAP_RD;
         end
         S_EMIT_RD: begin
            if (out_free) begin
               rd_en     = 1'b1;
               rd_addr_a = pos_ff[AW-1:0];
               state_in  = S_EMIT_LOAD;
            end
         end
         S_EMIT_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = INDEX_W'(rd_data_a[AW-1:0]);
            rsp_last_in  = emit_last;
            rsp_ovf_in   = ovf_ff;
            pos_in       = pos_ff + CW'(1);
            if (emit_last) begin
               count_in = '0;
               high_in  = '0;
               low_in   = LEVEL_TOP;
               ovf_in   = 1'b0;
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         high_ff      <= '0;
         low_ff       <= LEVEL_TOP;
         ovf_ff       <= 1'b0;
         lv_ff        <= '0;
         pos_ff       <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         high_ff      <= high_in;
         low_ff       <= low_in;
         ovf_ff       <= ovf_in;
         lv_ff        <= lv_in;
         pos_ff       <= pos_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_logical_index = rsp_index_ff;
   assign rsp_last_result   = rsp_last_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

// ===== rtl/blvr_checker.sv =====
// Port-level checks for the bidi level visual reorder unit, bound to the top level.
module blvr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [blvr_pkg::LEVEL_W-1:0]  req_level,
   input logic                          req_end_of_line,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [blvr_pkg::INDEX_W-1:0]  rsp_logical_index,
   input logic                          rsp_last_result,
   input logic                          rsp_overflow
);

   import blvr_pkg::*;

   logic req_beat;
   logic level_seen;

   assign req_beat   = req_valid && !req_stall;
   assign level_seen = |req_level;

   // A result beat held back by the consumer keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_logical_index)
         && $stable(rsp_last_result) && $stable(rsp_overflow))
      else $error("stalled result beat changed");

   // The last beat of a line starts reordering, so no further level is taken at once.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && req_end_of_line |=> req_stall)
      else $error("input not stalled after end of line");

   // Any other level beat leaves the input open for the next one, whatever its level.
   assert property (@(posedge clock) disable iff (reset)
      req_beat && !req_end_of_line && (level_seen || !level_seen) |=> !req_stall)
      else $error("input stalled in the middle of a line");

   // A new result only appears out of the reordering phase.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised while loading a line");

endmodule

bind bidi_level_visual_reorder_unit blvr_checker u_blvr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_level         (req_level),
   .req_end_of_line   (req_end_of_line),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_logical_index (rsp_logical_index),
   .rsp_last_result   (rsp_last_result),
   .rsp_overflow      (rsp_overflow)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the bidi level visual reorder unit, with a line-order predictor.
`timescale 1ns / 1ps

module tb;
   import blvr_pkg::*;

   localparam int LINE_CAP     = 64;
   localparam int RANDOM_ITEMS = 360;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DIR_ROWS     = 23;

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic               last;
      logic               ovf;
   } beat_type;

   // A directed row; n_typed > 0 on a line end means the visual order is given by hand.
   typedef struct packed {
      logic [LEVEL_W-1:0]       lvl;
      logic                     eol;
      logic [2:0]               n_typed;
      logic [0:3][INDEX_W-1:0]  typed;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic                req_end_of_line = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_logical_index;
   logic                rsp_last_result;
   logic                rsp_overflow;

   // Predictor state for the line being loaded.
   logic [LEVEL_W-1:0]      line_levels [LINE_CAP];
   int                      line_len = 0;
   logic [LEVEL_W-1:0]      line_high = '0;
   logic [LEVEL_W-1:0]      line_low = LEVEL_TOP;
   logic                    line_dropped = 1'b0;
   int                      typed_count = 0;
   logic [0:3][INDEX_W-1:0] typed_index;

   beat_type visual_order_q [$];
   int       errors = 0;
   int       cycle_count = 0;
   int       snd_idle_pct = 13;
   int       rcv_idle_pct = 64;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{7'd0,   1'b1, 3'd1, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd127, 1'b1, 3'd1, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd126, 1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd126, 1'b1, 3'd2, '{6'd0, 6'd1, 6'd0, 6'd0}},
      '{7'd1,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd1,   1'b1, 3'd2, '{6'd1, 6'd0, 6'd0, 6'd0}},
      '{7'd2,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd2,   1'b1, 3'd2, '{6'd0, 6'd1, 6'd0, 6'd0}},
      '{7'd0,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd1,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd1,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd0,   1'b1, 3'd4, '{6'd0, 6'd2, 6'd1, 6'd3}},
      '{7'd125, 1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd0,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd127, 1'b1, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd1,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd2,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd2,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd1,   1'b1, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd64,  1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd63,  1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd0,   1'b0, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}},
      '{7'd127, 1'b1, 3'd0, '{6'd0, 6'd0, 6'd0, 6'd0}}
   };

   bidi_level_visual_reorder_unit #(.MAX_LEN(LINE_CAP)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_level         (req_level),
      .req_end_of_line   (req_end_of_line),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_logical_index (rsp_logical_index),
      .rsp_last_result   (rsp_last_result),
      .rsp_overflow      (rsp_overflow)
   );

   always #6 clock = ~clock;

   function automatic void queue_expected(input beat_type bt);
      visual_order_q.insert(visual_order_q.size(), bt);
   endfunction

   // Reverses every maximal run at or above each level, highest first, down to the lowest odd level.
   function automatic void predict_visual_order();
      logic [INDEX_W-1:0] ord [LINE_CAP];
      logic [INDEX_W-1:0] t;
      int                 bottom, lv, i, j, a, b;
      beat_type           bt;
      bottom = line_low[0] ? int'(line_low) : int'(line_low) + 1;
      for (i = 0; i < line_len; i++) ord[i] = INDEX_W'(i);
      for (lv = int'(line_high); lv >= bottom && lv > 0; lv--) begin
         i = 0;
         while (i < line_len) begin
            if (int'(line_levels[ord[i]]) < lv) begin
               i++;
            end else begin
               j = i;
               while (j < line_len && int'(line_levels[ord[j]]) >= lv) j++;
               a = i;
               b = j - 1;
               while (a < b) begin
                  t = ord[a];
                  ord[a] = ord[b];
                  ord[b] = t;
                  a++;
                  b--;
               end
               i = j;
            end
         end
      end
      for (i = 0; i < line_len; i++) begin
         bt.idx  = ord[i];
         bt.last = (i == line_len - 1);
         bt.ovf  = line_dropped;
         queue_expected(bt);
      end
   endfunction

   function automatic void absorb_level(input logic [LEVEL_W-1:0] lvl_in, input logic eol);
      logic [LEVEL_W-1:0] lvl;
      beat_type           bt;
      lvl = (lvl_in > LEVEL_TOP) ? LEVEL_TOP : lvl_in;
      if (line_len < LINE_CAP) begin
         line_levels[line_len] = lvl;
         line_len++;
         if (lvl > line_high) line_high = lvl;
         if (lvl < line_low) line_low = lvl;
      end else begin
         line_dropped = 1'b1;
      end
      if (eol) begin
         if (typed_count != 0) begin
            for (int k = 0; k < typed_count; k++) begin
               bt.idx  = typed_index[k];
               bt.last = (k == typed_count - 1);
               bt.ovf  = 1'b0;
               queue_expected(bt);
            end
         end else begin
            predict_visual_order();
         end
         line_len     = 0;
         line_high    = '0;
         line_low     = LEVEL_TOP;
         line_dropped = 1'b0;
         typed_count  = 0;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [LEVEL_W-1:0] lvl, input logic eol);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_level       <= lvl;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_level(lvl, eol);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (visual_order_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual index %0d",
                     $time, rsp_logical_index);
         end else begin
            want = visual_order_q.pop_front();
            if (rsp_logical_index !== want.idx) begin
               errors++;
               $display("%0t: logical_index mismatch: expected %0d, actual %0d",
                        $time, want.idx, rsp_logical_index);
            end
            if (rsp_last_result !== want.last) begin
               errors++;
               $display("%0t: last_result mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_last_result);
            end
            if (rsp_overflow !== want.ovf) begin
               errors++;
               $display("%0t: overflow mismatch: expected %0b, actual %0b",
                        $time, want.ovf, rsp_overflow);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int                 sent;
      int                 len;
      int                 pick;
      int                 level_top;
      logic [LEVEL_W-1:0] lvl;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[r]) begin
         typed_count = dir_rows[r].n_typed;
         typed_index = dir_rows[r].typed;
         send_beat(dir_rows[r].lvl, dir_rows[r].eol);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 13;
            rcv_idle_pct = 64;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 64;
            rcv_idle_pct = 13;
         end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         pick = $urandom_range(99);
         // Long lines straddle capacity; they keep to low levels so the passes stay short.
         if (pick < 7) begin
            len       = $urandom_range(62, 68);
            level_top = 5;
         end else begin
            len       = $urandom_range(1, 14);
            pick      = $urandom_range(99);
            level_top = (pick < 40) ? 3 : (pick < 80) ? 15 : 127;
         end
         for (int k = 0; k < len; k++) begin
            lvl = LEVEL_W'($urandom_range(level_top));
            send_beat(lvl, k == len - 1);
         end
         sent += len;
      end
      req_valid <= 1'b0;

      while (visual_order_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
